### design/battery_gauge_moving_average_defines.svh
// Assertion macros used by the battery gauge top module.
`ifndef BATTERY_GAUGE_MOVING_AVERAGE_DEFINES_SVH
`define BATTERY_GAUGE_MOVING_AVERAGE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BGMA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BGMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bgma_pkg.sv
package bgma_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 16;
  localparam int SCALE_W   = 20;
  localparam int MV_W      = 14;
  localparam int CHG_W     = 10;
  localparam int PROD_W    = SUM_W + SCALE_W;
  localparam int FRAC_W    = 16;
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 14;
  localparam int DIV_CNT_W = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [MV_W-1:0]  MV_MAX      = 14'd16383;
  localparam logic [CHG_W-1:0] CHARGE_FULL = 10'd1000;

  localparam logic [SCALE_W-1:0] VOLT_SCALE_RST = 20'd240217;
  localparam logic [MV_W-1:0]    EMPTY_MV_RST   = 14'd10500;
  localparam logic [MV_W-1:0]    FULL_MV_RST    = 14'd13800;
  localparam logic [MV_W-1:0]    LOW_MV_RST     = 14'd11000;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MV     = 3'd3;

  typedef enum logic [1:0] {
    WIN_NOP,
    WIN_FILL,
    WIN_READ,
    WIN_UPDATE
  } win_op_t;

  typedef struct packed {
    logic primed;
    logic fill_last;
  } win_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_UPDATE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_MV_GO,
    ST_MV_WAIT,
    ST_CH_MUL,
    ST_CH_GO,
    ST_CH_WAIT,
    ST_DONE
  } state_t;

endpackage

### design/bgma_win.sv
module bgma_win
  import bgma_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  win_op_t             op,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]    sum,
  output win_stat_t           stat
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] old_r;
  logic [IDX_W-1:0]    slot_r;
  logic [IDX_W-1:0]    fill_r;
  logic [SUM_W-1:0]    sum_r;
  logic                primed_r;

  always_ff @(posedge clk) begin
    if (op == WIN_FILL) begin
      mem[fill_r] <= sample;
    end else if (op == WIN_UPDATE) begin
      mem[slot_r] <= sample;
    end
    if (op == WIN_READ) begin
      old_r <= mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      primed_r <= 1'b0;
    end else begin
      case (op)
        WIN_FILL: begin
          sum_r <= sum_r + SUM_W'(sample);
          if (fill_r == LAST_IDX) begin
            fill_r   <= '0;
            primed_r <= 1'b1;
          end else begin
            fill_r <= fill_r + 1'b1;
          end
        end
        WIN_UPDATE: begin
          sum_r  <= sum_r - SUM_W'(old_r) + SUM_W'(sample);
          slot_r <= (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign sum            = sum_r;
  assign stat.primed    = primed_r;
  assign stat.fill_last = (fill_r == LAST_IDX);

endmodule

### design/bgma_div.sv
module bgma_div
  import bgma_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quo,
  output div_stat_t            stat
);

  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   rem_w;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign rem_w = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff  = rem_w - {1'b0, den_r};
  assign fits  = (rem_w >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? diff[DIV_DEN_W-1:0] : rem_w[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### design/battery_gauge_moving_average.sv
// Battery gauge with a moving average over the last WINDOW ADC samples. Each input word
// yields one result word with the window mean, the battery voltage in millivolts, the charge
// in tenths of a percent and a low battery flag. The first word after reset first fills the
// sample window with its own sample. One shared 24-step restoring divider is run up to three
// times per word: for the mean, the voltage and, unless the charge is zero, the charge. A
// finished result waits in an output register, and the next word is taken once the result
// has been loaded there.
`include "battery_gauge_moving_average_defines.svh"

module battery_gauge_moving_average
  import bgma_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  out_average_raw,
  output logic [MV_W-1:0]      out_battery_mv,
  output logic [CHG_W-1:0]     out_charge_tenths,
  output logic                 out_low_battery,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data
);

  state_t state_r, state_nxt;

  logic [SCALE_W-1:0]  volt_scale_r;
  logic [MV_W-1:0]     empty_mv_r;
  logic [MV_W-1:0]     full_mv_r;
  logic [MV_W-1:0]     low_mv_r;

  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [MV_W-1:0]     mv_r, mv_nxt;
  logic [CHG_W-1:0]    charge_r, charge_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_avg_r, out_avg_nxt;
  logic [MV_W-1:0]     out_mv_r, out_mv_nxt;
  logic [CHG_W-1:0]    out_charge_r, out_charge_nxt;
  logic                out_low_r, out_low_nxt;

  win_op_t             win_op;
  win_stat_t           win_stat;
  logic [SUM_W-1:0]    win_sum;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  div_stat_t            div_stat;

  logic [SUM_W-1:0]    mul_a;
  logic [SCALE_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [MV_W-1:0]     mv_diff;
  logic                charge_zero;

  bgma_win #(
    .WINDOW(WINDOW)
  ) u_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (win_op),
    .sample (sample_r),
    .sum    (win_sum),
    .stat   (win_stat)
  );

  bgma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign mul_p       = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mv_diff     = mv_r - empty_mv_r;
  assign charge_zero = (full_mv_r <= empty_mv_r) || (mv_r <= empty_mv_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_scale_r <= VOLT_SCALE_RST;
      empty_mv_r   <= EMPTY_MV_RST;
      full_mv_r    <= FULL_MV_RST;
      low_mv_r     <= LOW_MV_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VOLT_SCALE: volt_scale_r <= cfg_data;
        CFG_EMPTY_MV:   empty_mv_r   <= cfg_data[MV_W-1:0];
        CFG_FULL_MV:    full_mv_r    <= cfg_data[MV_W-1:0];
        CFG_LOW_MV:     low_mv_r     <= cfg_data[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    avg_r        <= avg_nxt;
    mv_r         <= mv_nxt;
    charge_r     <= charge_nxt;
    prod_r       <= prod_nxt;
    out_avg_r    <= out_avg_nxt;
    out_mv_r     <= out_mv_nxt;
    out_charge_r <= out_charge_nxt;
    out_low_r    <= out_low_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sample_nxt     = sample_r;
    avg_nxt        = avg_r;
    mv_nxt         = mv_r;
    charge_nxt     = charge_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r;
    out_avg_nxt    = out_avg_r;
    out_mv_nxt     = out_mv_r;
    out_charge_nxt = out_charge_r;
    out_low_nxt    = out_low_r;
    win_op         = WIN_NOP;
    div_start      = 1'b0;
    div_num        = DIV_NUM_W'(win_sum);
    div_den        = DIV_DEN_W'(WINDOW);
    mul_a          = win_sum;
    mul_b          = volt_scale_r;
    in_ready       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sample_nxt = in_sample;
          state_nxt  = win_stat.primed ? ST_READ : ST_FILL;
        end
      end
      ST_FILL: begin
        win_op = WIN_FILL;
        if (win_stat.fill_last) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        win_op    = WIN_READ;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        win_op    = WIN_UPDATE;
        state_nxt = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        div_start = 1'b1;
        prod_nxt  = mul_p;
        state_nxt = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_stat.done) begin
          avg_nxt   = div_quo[SAMPLE_W-1:0];
          state_nxt = ST_MV_GO;
        end
      end
      ST_MV_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(prod_r[PROD_W-1:FRAC_W]);
        state_nxt = ST_MV_WAIT;
      end
      ST_MV_WAIT: begin
        if (div_stat.done) begin
          mv_nxt    = (div_quo > DIV_NUM_W'(MV_MAX)) ? MV_MAX : div_quo[MV_W-1:0];
          state_nxt = ST_CH_MUL;
        end
      end
      ST_CH_MUL: begin
        mul_a = SUM_W'(mv_diff);
        mul_b = SCALE_W'(CHARGE_FULL);
        if (charge_zero) begin
          charge_nxt = '0;
          state_nxt  = ST_DONE;
        end else begin
          prod_nxt  = mul_p;
          state_nxt = ST_CH_GO;
        end
      end
      ST_CH_GO: begin
        div_start = 1'b1;
        div_num   = prod_r[DIV_NUM_W-1:0];
        div_den   = full_mv_r - empty_mv_r;
        state_nxt = ST_CH_WAIT;
      end
      ST_CH_WAIT: begin
        if (div_stat.done) begin
          charge_nxt = (div_quo > DIV_NUM_W'(CHARGE_FULL)) ? CHARGE_FULL
                                                          : div_quo[CHG_W-1:0];
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_avg_nxt    = avg_r;
          out_mv_nxt     = mv_r;
          out_charge_nxt = charge_r;
          out_low_nxt    = (mv_r < low_mv_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_average_raw   = out_avg_r;
  assign out_battery_mv    = out_mv_r;
  assign out_charge_tenths = out_charge_r;
  assign out_low_battery   = out_low_r;

  `BGMA_ASSERT_SAME(a_charge_range, out_valid, out_charge_tenths <= CHARGE_FULL, "charge above full")
  `BGMA_ASSERT_SAME(a_low_flag, out_valid, out_low_battery == (out_battery_mv < low_mv_r), "low flag mismatch")
  `BGMA_ASSERT_SAME(a_inverted_zero, out_valid && (full_mv_r <= empty_mv_r), out_charge_tenths == '0, "charge with inverted thresholds")
  `BGMA_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider started while busy")
  `BGMA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "word taken while another is in work")

endmodule
